// ----- rtl/smwd_pkg.sv -----
// Shared types and constants for the SGR mouse wheel decoder.
// No dependencies; imported by every module of the block.
package smwd_pkg;

    // Width of the pending wheel count and of the result word
    localparam int COUNT_WIDTH = 16;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    // Bytes that frame a report and bound its digits
    localparam logic [7:0] BYTE_ESC      = 8'h1B;
    localparam logic [7:0] BYTE_BRACKET  = 8'h5B;  // '['
    localparam logic [7:0] BYTE_LT       = 8'h3C;  // '<'
    localparam logic [7:0] BYTE_TERM_UP  = 8'h4D;  // 'M'
    localparam logic [7:0] BYTE_TERM_LO  = 8'h6D;  // 'm'
    localparam logic [7:0] BYTE_ZERO     = 8'h30;  // '0'
    localparam logic [7:0] BYTE_NINE     = 8'h39;  // '9'

    // Button code bits that select a wheel event and its direction
    localparam int WHEEL_BIT = 6;
    localparam int DIR_BIT   = 0;

    // Item kinds carried on tuser
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_POLL = 1'b1
    } opcode_t;

    // Report parser phases
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ESC     = 3'd1,
        PH_BRACKET = 3'd2,
        PH_DIGITS  = 3'd3,
        PH_SKIP    = 3'd4
    } phase_t;

    // Requests from the parser and the poll path to the counter
    typedef struct packed {
        logic inc;    // wheel up notch
        logic dec;    // wheel down notch
        logic poll;   // return the count and clear it
    } count_req_t;

endpackage

// ----- rtl/smwd_parser.sv -----
// Byte-level parser for SGR mouse reports (ESC [ < digits ... M/m).
// Depends on smwd_pkg; emits one wheel up or down request per finished report with a wheel button code.
module smwd_parser
    import smwd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_en,     // a terminal byte is consumed this cycle
    input  logic [7:0] byte_value,
    output logic       notch_up,
    output logic       notch_down
);

    phase_t     phase_reg, phase_next;
    logic [6:0] code_reg, code_next;
    logic       seen_reg, seen_next;

    logic       is_term;
    logic       is_digit;
    logic [3:0] digit;
    logic       finish;

    assign is_term  = (byte_value == BYTE_TERM_UP) || (byte_value == BYTE_TERM_LO);
    assign is_digit = (byte_value >= BYTE_ZERO) && (byte_value <= BYTE_NINE);
    assign digit    = 4'(byte_value - BYTE_ZERO);

    // Advance the parse phase and the button code accumulator
    always_comb
    begin
        phase_next = phase_reg;
        code_next  = code_reg;
        seen_next  = seen_reg;
        finish     = 1'b0;
        if (byte_en)
        begin
            unique case (phase_reg)
                PH_ESC:
                begin
                    if (byte_value == BYTE_BRACKET)
                        phase_next = PH_BRACKET;
                    else
                        phase_next = (byte_value == BYTE_ESC) ? PH_ESC : PH_IDLE;
                end
                PH_BRACKET:
                begin
                    if (byte_value == BYTE_LT)
                    begin
                        phase_next = PH_DIGITS;
                        code_next  = '0;
                        seen_next  = 1'b0;
                    end
                    else
                        phase_next = (byte_value == BYTE_ESC) ? PH_ESC : PH_IDLE;
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        // code * 10 + digit, modulo 128
                        code_next = (code_reg << 3) + (code_reg << 1) + 7'(digit);
                        seen_next = 1'b1;
                    end
                    else if (is_term)
                        finish = 1'b1;
                    else
                        phase_next = PH_SKIP;
                end
                PH_SKIP:
                begin
                    if (is_term)
                        finish = 1'b1;
                end
                default:
                begin
                    phase_next = (byte_value == BYTE_ESC) ? PH_ESC : PH_IDLE;
                end
            endcase
            if (finish)
            begin
                phase_next = PH_IDLE;
                code_next  = '0;
                seen_next  = 1'b0;
            end
        end
    end

    // Flag a wheel notch when a report with digits and a wheel button code ends
    assign notch_up   = finish && seen_reg && code_reg[WHEEL_BIT] && !code_reg[DIR_BIT];
    assign notch_down = finish && seen_reg && code_reg[WHEEL_BIT] && code_reg[DIR_BIT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            code_reg  <= '0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            code_reg  <= code_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

// ----- rtl/smwd_counter.sv -----
// Saturating wheel notch counter with the result word register.
// Depends on smwd_pkg; fed by the parser and the poll path of the top level.
module smwd_counter
    import smwd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  count_req_t             req,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COUNT_WIDTH-1:0] out_count
);

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   valid_reg, valid_next;
    logic [COUNT_WIDTH-1:0] data_reg, data_next;

    // Step or clear the pending count
    always_comb
    begin
        count_next = count_reg;
        priority if (req.poll)
            count_next = '0;
        else if (req.inc && (count_reg != COUNT_MAX))
            count_next = count_reg + 1'b1;
        else if (req.dec && (count_reg != COUNT_MIN))
            count_next = count_reg - 1'b1;
    end

    // Load the result word on a poll, drop it once taken
    always_comb
    begin
        valid_next = valid_reg && !out_ready;
        data_next  = data_reg;
        if (req.poll)
        begin
            valid_next = 1'b1;
            data_next  = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_count = data_reg;

endmodule

// ----- rtl/sgr_mouse_wheel_decoder.sv -----
// Top level of the SGR mouse wheel decoder: input register, parser, counter.
// Depends on smwd_pkg, smwd_parser and smwd_counter.
//
//  channel | tvalid/tready     | tdata                 | tuser
//  --------+-------------------+-----------------------+----------------------
//  s_*     | input word        | [7:0] byte_value      | [0] opcode (1 = poll)
//  m_*     | result word       | [15:0] notch_count    | -
//
// One word a cycle while nothing stalls: a word is held in the input register and is
// consumed there; a poll shows its count on m_* the cycle after.
// A byte word never waits; a poll waits only while the result register is
// full and m_tready is low, which then holds s_tready low.
// rst_n clears parse state, the count and both valid flags at once.
module sgr_mouse_wheel_decoder
    import smwd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] byte_value
    input  logic                   s_tuser,   // [0] opcode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [COUNT_WIDTH-1:0] m_tdata    // [15:0] notch_count
);

    logic       in_vld_reg;
    opcode_t    in_op_reg;
    logic [7:0] in_byte_reg;

    logic       advance;
    logic       byte_en;
    logic       poll_en;
    logic       notch_up;
    logic       notch_down;
    count_req_t req;

    // Consume the held word; a poll needs room in the result register
    assign advance  = in_vld_reg && ((in_op_reg == OP_BYTE) || !m_tvalid || m_tready);
    assign byte_en  = advance && (in_op_reg == OP_BYTE);
    assign poll_en  = advance && (in_op_reg == OP_POLL);
    assign s_tready = !in_vld_reg || advance;

    // Hold the accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_tready)
            in_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= opcode_t'(s_tuser);
            in_byte_reg <= s_tdata;
        end
    end

    smwd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_en    (byte_en),
        .byte_value (in_byte_reg),
        .notch_up   (notch_up),
        .notch_down (notch_down)
    );

    assign req.inc  = notch_up;
    assign req.dec  = notch_down;
    assign req.poll = poll_en;

    smwd_counter u_counter (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_count (m_tdata)
    );

`ifndef NO_ASSERTIONS
    // A consumed poll always shows up as a result word
    a_poll_result: assert property (@(posedge clk) disable iff (!rst_n)
        poll_en |=> m_tvalid)
        else $error("poll consumed without a result word");

    // A pending result is never overwritten by a new poll
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(poll_en && m_tvalid && !m_tready))
        else $error("result word overwritten while stalled");

    // An empty input register always takes a word
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |-> s_tready)
        else $error("input stalled while empty");

    // A wheel event comes from a byte, never from a poll, and is never up and down at once
    a_notch_src: assert property (@(posedge clk) disable iff (!rst_n)
        (notch_up || notch_down) |-> (byte_en && !(notch_up && notch_down)))
        else $error("wheel event without a byte");
`endif

endmodule
